@@ rtl/mmpd_pkg.sv @@
// Shared constants for the multi-motor PD drive block.
package mmpd_pkg;

  localparam int unsigned MOTOR_COUNT = 4;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [1:0] MODE_TARGET = 2'd0;
  localparam logic [1:0] MODE_UPDATE = 2'd1;
  localparam logic [1:0] MODE_DIRECT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_KP        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KD        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_INV   = 3'd4;

  localparam logic signed [23:0] KP_RESET        = 24'sd38400;
  localparam logic signed [23:0] KD_RESET        = -24'sd256;
  localparam logic [12:0]        MAX_SPEED_RESET = 13'd8000;
  localparam logic [12:0]        MIN_SPEED_RESET = 13'd3000;
  localparam logic [3:0]         DIR_INV_RESET   = 4'd10;

  // restoring divider: one quotient bit per cycle
  localparam int unsigned DIV_STEPS = 41;
  localparam int unsigned CNT_W     = 6;

endpackage

@@ rtl/multi_motor_pd_drive.sv @@
// Four-motor PD position loop with drive shaping and PWM duty/direction output.
//
//  channel | direction | handshake             | word
//  --------+-----------+-----------------------+-----------------------------------
//  in      | input     | in_valid_i/in_stall_o | mode, motor, value, timestamp_us
//  out     | output    | out_valid_o/out_stall_i | motor_res, direction_level, duty, drive
//  cfg     | input     | cfg_we_i              | cfg_index_i, cfg_wdata_i
//
// Target write: stored, no result. Direct drive: sum, clamp, output steps. Update:
// Kp and Kd multiply on one shared 24x17 multiplier, 41-step bit-serial divider
// (skipped for zero elapsed time), sum, clamp, output. One word is in flight at a time.
// The next word is taken while a result waits in the output register.
// A stalled result holds the block in its last step until the register frees.
// Reset loads default gains, limits and inversion mask and zeroes all per-motor state.
module multi_motor_pd_drive (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [mmpd_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [mmpd_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [1:0]                           mode_i,
  input  logic [1:0]                           motor_i,
  input  logic signed [15:0]                   value_i,
  input  logic [31:0]                          timestamp_us_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [1:0]                           motor_res_o,
  output logic                                 direction_level_o,
  output logic [12:0]                          duty_o,
  output logic signed [13:0]                   drive_o
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_MULP = 7'b0000010,
    ST_MULD = 7'b0000100,
    ST_DIV  = 7'b0001000,
    ST_SUM  = 7'b0010000,
    ST_CLMP = 7'b0100000,
    ST_OUT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic signed [23:0] kp_q, kd_q;
  logic [12:0]        max_speed_q, min_speed_q;
  logic [3:0]         dir_inv_q;

  logic signed [15:0] tgt_q   [mmpd_pkg::MOTOR_COUNT];
  logic signed [15:0] ppos_q  [mmpd_pkg::MOTOR_COUNT];
  logic [31:0]        ptime_q [mmpd_pkg::MOTOR_COUNT];

  logic [1:0]         motor_q;
  logic signed [16:0] err_q, delta_q;
  logic [31:0]        dt_q;
  logic signed [40:0] acc_q;
  logic [40:0]        num_q;
  logic               neg_q;
  logic [31:0]        rem_q;
  logic [mmpd_pkg::CNT_W-1:0] cnt_q;
  logic signed [43:0] s_q;
  logic signed [21:0] sc_q;

  logic               out_valid_q;
  logic [1:0]         motor_res_q;
  logic               dir_q;
  logic [12:0]        duty_q;
  logic signed [13:0] drive_q;

  logic in_acc, motor_ok, out_free;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign motor_ok   = 32'(motor_i) < mmpd_pkg::MOTOR_COUNT;
  assign out_free   = !out_valid_q || !out_stall_i;

  // shared multiplier
  logic signed [23:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [40:0] prod;
  assign mul_a = (state_q == ST_MULP) ? kp_q  : kd_q;
  assign mul_b = (state_q == ST_MULP) ? err_q : delta_q;
  assign prod  = mul_a * mul_b;

  // divider step
  logic [32:0] trial, trial_sub;
  logic        qbit;
  assign trial     = {rem_q, num_q[40]};
  assign trial_sub = trial - {1'b0, dt_q};
  assign qbit      = !trial_sub[32];

  // sum
  logic signed [43:0] quo_ext, sum;
  assign quo_ext = neg_q ? -$signed({3'd0, num_q}) : $signed({3'd0, num_q});
  assign sum     = {{3{acc_q[40]}}, acc_q} + quo_ext;

  // inversion and clamp
  logic signed [43:0] s_inv, hi, s_clmp;
  assign s_inv = dir_inv_q[motor_q] ? -s_q : s_q;
  assign hi    = $signed({23'd0, max_speed_q, 8'd0});
  always_comb begin
    if (s_inv > hi) begin
      s_clmp = hi;
    end else if (s_inv < -hi) begin
      s_clmp = -hi;
    end else begin
      s_clmp = s_inv;
    end
  end

  // boost, truncation and duty
  logic signed [21:0] lo, sb, mag;
  logic signed [13:0] drv;
  logic signed [14:0] dsum;
  logic [12:0]        duty_n;
  logic               pos;
  assign lo = $signed({1'b0, min_speed_q, 8'd0});
  always_comb begin
    sb = sc_q;
    if (sc_q > 22'sd0 && sc_q < lo) begin
      sb = lo;
    end else if (sc_q < 22'sd0 && sc_q > -lo) begin
      sb = -lo;
    end
    mag  = -sb;
    drv  = sb[21] ? -14'(mag >>> 8) : 14'(sb >>> 8);
    pos  = (sb > 22'sd0);
    dsum = $signed({2'd0, max_speed_q}) + 15'(drv);
    if (pos) begin
      duty_n = drv[12:0];
    end else if (dsum[14]) begin
      duty_n = 13'd0;
    end else begin
      duty_n = dsum[12:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && motor_ok) begin
          if (mode_i == mmpd_pkg::MODE_UPDATE) begin
            state_d = ST_MULP;
          end else if (mode_i == mmpd_pkg::MODE_DIRECT) begin
            state_d = ST_SUM;
          end
        end
      end
      ST_MULP: state_d = ST_MULD;
      ST_MULD: state_d = (dt_q == 32'd0) ? ST_SUM : ST_DIV;
      ST_DIV: begin
        if (cnt_q == mmpd_pkg::CNT_W'(mmpd_pkg::DIV_STEPS - 1)) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM:  state_d = ST_CLMP;
      ST_CLMP: state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      kp_q        <= mmpd_pkg::KP_RESET;
      kd_q        <= mmpd_pkg::KD_RESET;
      max_speed_q <= mmpd_pkg::MAX_SPEED_RESET;
      min_speed_q <= mmpd_pkg::MIN_SPEED_RESET;
      dir_inv_q   <= mmpd_pkg::DIR_INV_RESET;
      for (int i = 0; i < int'(mmpd_pkg::MOTOR_COUNT); i++) begin
        tgt_q[i]   <= '0;
        ppos_q[i]  <= '0;
        ptime_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          mmpd_pkg::CFG_KP:        kp_q        <= $signed(cfg_wdata_i);
          mmpd_pkg::CFG_KD:        kd_q        <= $signed(cfg_wdata_i);
          mmpd_pkg::CFG_MAX_SPEED: max_speed_q <= cfg_wdata_i[12:0];
          mmpd_pkg::CFG_MIN_SPEED: min_speed_q <= cfg_wdata_i[12:0];
          mmpd_pkg::CFG_DIR_INV:   dir_inv_q   <= cfg_wdata_i[3:0];
          default: ;
        endcase
      end
      if (in_acc && motor_ok) begin
        if (mode_i == mmpd_pkg::MODE_TARGET) begin
          tgt_q[motor_i] <= value_i;
        end else if (mode_i == mmpd_pkg::MODE_UPDATE) begin
          ppos_q[motor_i]  <= value_i;
          ptime_q[motor_i] <= timestamp_us_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        motor_q <= motor_i;
        err_q   <= 17'(tgt_q[motor_i]) - 17'(value_i);
        delta_q <= 17'(value_i) - 17'(ppos_q[motor_i]);
        dt_q    <= timestamp_us_i - ptime_q[motor_i];
        acc_q   <= {{17{value_i[15]}}, value_i, 8'd0};
        num_q   <= '0;
        neg_q   <= 1'b0;
      end
      ST_MULP: acc_q <= prod;
      ST_MULD: begin
        neg_q <= prod[40];
        num_q <= (dt_q == 32'd0) ? 41'd0 : (prod[40] ? 41'(-prod) : 41'(prod));
        rem_q <= '0;
        cnt_q <= '0;
      end
      ST_DIV: begin
        rem_q <= qbit ? trial_sub[31:0] : trial[31:0];
        num_q <= {num_q[39:0], qbit};
        cnt_q <= cnt_q + 1'b1;
      end
      ST_SUM:  s_q  <= sum;
      ST_CLMP: sc_q <= s_clmp[21:0];
      ST_OUT: begin
        if (out_free) begin
          motor_res_q <= motor_q;
          dir_q       <= !pos;
          duty_q      <= duty_n;
          drive_q     <= drv;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o       = out_valid_q;
  assign motor_res_o       = motor_res_q;
  assign direction_level_o = dir_q;
  assign duty_o            = duty_q;
  assign drive_o           = drive_q;

endmodule

@@ rtl/mmpd_checker.sv @@
// Port-level assertions for the multi-motor PD drive, bound to the top level.
module mmpd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic [1:0]                      mode_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic                            direction_level_o,
  input logic [12:0]                     duty_o,
  input logic signed [13:0]              drive_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_busy_after_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o
      && (mode_i == mmpd_pkg::MODE_UPDATE || mode_i == mmpd_pkg::MODE_DIRECT)
      |=> in_stall_o)
    else $error("input taken again while drive word in progress");

  a_target_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && mode_i == mmpd_pkg::MODE_TARGET |=> !in_stall_o)
    else $error("target write left the block busy");

  a_fwd_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !direction_level_o |-> !drive_o[13] && duty_o == drive_o[12:0])
    else $error("forward duty does not match drive");

  a_rev_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && direction_level_o |-> drive_o[13] || drive_o == 14'sd0)
    else $error("reverse direction with positive drive");

endmodule

bind multi_motor_pd_drive mmpd_checker u_mmpd_checker (.*);
